// ===== rtl/bbc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbc_pkg: shared types and constants of the 3x3 box blur
// widths of the stream words, lane control word and divisor codes
// ----------------------------------------------------------------------------
package bbc_pkg;

    // fixed widths of the stream fields
    localparam int PIX_BITS  = 16;
    localparam int NUM_LANES = 3;
    localparam int CFG_BITS  = 11;

    // defaults of the top level parameters
    localparam int MAX_DIM_DEF      = 1024;
    localparam int CHANNEL_BITS_DEF = 16;

    // image size after reset
    localparam int DIM_RESET = 1024;

    // number of window cells that lie inside the image
    typedef enum logic [1:0] {
        DIV1 = 2'd0,
        DIV4 = 2'd1,
        DIV6 = 2'd2,
        DIV9 = 2'd3
    } div_t;

    // control word broadcast to every channel lane
    typedef struct packed {
        logic       shift;   // shift window left, load new right column
        logic       sum_en;  // register the clipped window sum
        logic [2:0] row_ok;  // window row inside the image, bit 0 = oldest
        logic [2:0] col_ok;  // window column inside the image, bit 0 = left
        div_t       div;     // divisor of the registered sum
    } lane_ctrl_t;

endpackage

// ===== rtl/bbc_lane.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbc_lane: one color channel of the box blur
// 3x3 window, clipped sum and division by reciprocal multiply
// ----------------------------------------------------------------------------
module bbc_lane #(
    parameter int CHANNEL_BITS = bbc_pkg::CHANNEL_BITS_DEF
) (
    input  logic                    clk,
    input  bbc_pkg::lane_ctrl_t     ctrl,
    input  logic [CHANNEL_BITS-1:0] older,
    input  logic [CHANNEL_BITS-1:0] newer,
    input  logic [CHANNEL_BITS-1:0] pix,
    output logic [CHANNEL_BITS-1:0] quot
);

    localparam int SUM_W = CHANNEL_BITS + 4;
    localparam int SH    = SUM_W + 4;
    localparam int MW    = SH - 2;
    localparam int PW    = SUM_W + MW;
    localparam longint unsigned M6_L = ((64'd1 << SH) + 64'd5) / 64'd6;
    localparam longint unsigned M9_L = ((64'd1 << SH) + 64'd8) / 64'd9;
    localparam logic [MW-1:0] M6 = MW'(M6_L);
    localparam logic [MW-1:0] M9 = MW'(M9_L);

    // win_reg[row][col], row 0 oldest, col 0 left
    logic [CHANNEL_BITS-1:0] win_reg [3][3];
    logic [SUM_W-1:0]        sum_reg;
    logic [SUM_W-1:0]        sum_next;
    bbc_pkg::div_t           div_reg;
    logic [MW-1:0]           recip;
    logic [PW-1:0]           prod;

    always_ff @(posedge clk)
    begin
        if (ctrl.shift)
        begin
            for (int r = 0; r < 3; r++)
            begin
                win_reg[r][0] <= win_reg[r][1];
                win_reg[r][1] <= win_reg[r][2];
            end
            win_reg[0][2] <= older;
            win_reg[1][2] <= newer;
            win_reg[2][2] <= pix;
        end
    end

    // masked sum of the cells inside the image
    always_comb
    begin
        sum_next = '0;
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                if (ctrl.row_ok[r] && ctrl.col_ok[c])
                begin
                    sum_next = sum_next + SUM_W'(win_reg[r][c]);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.sum_en)
        begin
            sum_reg <= sum_next;
            div_reg <= ctrl.div;
        end
    end

    // exact for every sum below 2**SUM_W
    assign recip = (div_reg == bbc_pkg::DIV9) ? M9 : M6;
    assign prod  = {{MW{1'b0}}, sum_reg} * {{SUM_W{1'b0}}, recip};

    always_comb
    begin
        unique case (div_reg)
            bbc_pkg::DIV1: quot = sum_reg[CHANNEL_BITS-1:0];
            bbc_pkg::DIV4: quot = sum_reg[2 +: CHANNEL_BITS];
            bbc_pkg::DIV6: quot = prod[SH +: CHANNEL_BITS];
            bbc_pkg::DIV9: quot = prod[SH +: CHANNEL_BITS];
            default:       quot = sum_reg[CHANNEL_BITS-1:0];
        endcase
    end

endmodule

// ===== rtl/bbc_merge.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbc_merge: output stage of the box blur
// gathers the lane quotients into one output word and holds it for the sink
// ----------------------------------------------------------------------------
module bbc_merge #(
    parameter int CHANNEL_BITS = bbc_pkg::CHANNEL_BITS_DEF
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        load,
    input  logic [bbc_pkg::NUM_LANES*CHANNEL_BITS-1:0]  quot_all,
    input  logic                                        last,
    output logic                                        free,
    output logic                                        m_axis_tvalid,
    input  logic                                        m_axis_tready,
    output logic [bbc_pkg::NUM_LANES*bbc_pkg::PIX_BITS-1:0] m_axis_tdata,
    output logic                                        m_axis_tlast
);

    localparam int PB = bbc_pkg::PIX_BITS;

    logic                                  valid_reg;
    logic [bbc_pkg::NUM_LANES*PB-1:0]      data_reg;
    logic [bbc_pkg::NUM_LANES*PB-1:0]      data_next;
    logic                                  last_reg;

    assign free = !valid_reg || m_axis_tready;

    always_comb
    begin
        for (int l = 0; l < bbc_pkg::NUM_LANES; l++)
        begin
            data_next[l*PB +: PB] = PB'(quot_all[l*CHANNEL_BITS +: CHANNEL_BITS]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= data_next;
            last_reg <= last;
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = data_reg;
    assign m_axis_tlast  = last_reg;

endmodule

// ===== rtl/box_blur_3x3_edge_clipped_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_blur_3x3_edge_clipped_unit: 3x3 box blur with clipped borders
// streams a square rgb image in raster order and returns the clipped mean
// ----------------------------------------------------------------------------
// usage
//   s_axis: one word per pixel; tdata = red, green, blue (low bits first),
//     tuser = opcode (1 marks a flush word). after the dim*dim pixels of a
//     frame the source sends dim+1 flush words to drain the last outputs.
//   m_axis: one word per output pixel, raster order; tdata = red, green,
//     blue means, tlast marks the frame's final pixel.
//   cfg: a write sets the image size (0 reads as 1, above MAX_DIM as
//     MAX_DIM) and restarts the frame; write only while the block is idle.
//   steps: a word with no output runs a line store read, then a window
//     shift with line store write; a word with an output runs read, shift,
//     clipped sum, then divide into the output register. its result reaches
//     m_axis through the window, sum and output registers.
//     the first output of a frame comes with input word dim+1.
//   stall: the output register keeps its word while m_axis_tready is low;
//     the block finishes the next word and waits to load it until the
//     register frees up, with s_axis_tready low meanwhile.
//   reset: counters and handshakes clear at once, size returns to 1024 (at most MAX_DIM);
//     the line stores need no clearing pass, since an entry not yet written
//     in the current frame always falls outside the clipped window.
// ----------------------------------------------------------------------------
module box_blur_3x3_edge_clipped_unit #(
    parameter int MAX_DIM      = bbc_pkg::MAX_DIM_DEF,
    parameter int CHANNEL_BITS = bbc_pkg::CHANNEL_BITS_DEF
) (
    input  logic                                            clk,
    input  logic                                            rst_n,
    // configuration write: image size
    input  logic                                            cfg_valid,
    output logic                                            cfg_ready,
    input  logic [bbc_pkg::CFG_BITS-1:0]                    cfg_data,
    // input stream
    input  logic                                            s_axis_tvalid,
    output logic                                            s_axis_tready,
    input  logic [bbc_pkg::NUM_LANES*bbc_pkg::PIX_BITS-1:0] s_axis_tdata,  // red_in, green_in, blue_in
    input  logic [0:0]                                      s_axis_tuser,  // opcode
    // output stream
    output logic                                            m_axis_tvalid,
    input  logic                                            m_axis_tready,
    output logic [bbc_pkg::NUM_LANES*bbc_pkg::PIX_BITS-1:0] m_axis_tdata,  // red_out, green_out, blue_out
    output logic                                            m_axis_tlast   // last_pixel
);

    localparam int NL    = bbc_pkg::NUM_LANES;
    localparam int PB    = bbc_pkg::PIX_BITS;
    localparam int COL_W = $clog2(MAX_DIM);
    localparam int ROW_W = $clog2(MAX_DIM + 2);
    localparam int MEM_W = NL * CHANNEL_BITS;
    localparam int RESET_DIM = (bbc_pkg::DIM_RESET > MAX_DIM) ? MAX_DIM : bbc_pkg::DIM_RESET;

    // one-hot item sequencer
    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SHIFT = 4'b0010,
        ST_SUM   = 4'b0100,
        ST_OUT   = 4'b1000
    } state_t;

    // what the current word means, decided from the positions when taken
    typedef struct packed {
        logic emit;    // word produces an output
        logic top;     // center on first row
        logic bottom;  // center on last row
        logic left;    // center on first column
        logic right;   // center on last column
        logic last;    // final output pixel of the frame
    } item_t;

    state_t             state_reg, state_next;
    item_t              item_reg, item_next;

    logic [ROW_W-1:0]   dim_reg, dim_next;
    logic [COL_W-1:0]   in_col_reg, in_col_next;
    logic [ROW_W-1:0]   in_row_reg, in_row_next;
    logic [COL_W-1:0]   out_col_reg, out_col_next;
    logic [COL_W-1:0]   out_row_reg, out_row_next;

    logic [COL_W-1:0]   col_reg;
    logic [MEM_W-1:0]   pix_reg, pix_next;
    logic [MEM_W-1:0]   older_q_reg;
    logic [MEM_W-1:0]   newer_q_reg;

    // line stores: two rows above the current input column
    logic [MEM_W-1:0]   older_mem [MAX_DIM];
    logic [MEM_W-1:0]   newer_mem [MAX_DIM];

    logic               in_acc;
    logic               cfg_acc;
    logic               frame_end;
    logic               in_col_wrap;
    logic               out_col_wrap;
    logic               out_free;
    logic               out_load;

    bbc_pkg::lane_ctrl_t        lane_ctrl;
    logic [NL*CHANNEL_BITS-1:0] quot_all;

    assign cfg_ready     = 1'b1;
    assign cfg_acc       = cfg_valid && cfg_ready;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    // size clamp on write
    always_comb
    begin
        if (cfg_data == '0)
        begin
            dim_next = ROW_W'(1);
        end
        else if (int'(cfg_data) > MAX_DIM)
        begin
            dim_next = ROW_W'(MAX_DIM);
        end
        else
        begin
            dim_next = ROW_W'(cfg_data);
        end
    end

    // item decode from the input and output positions
    always_comb
    begin
        item_next.emit   = (in_row_reg != '0) &&
                           !((in_row_reg == ROW_W'(1)) && (in_col_reg == '0));
        item_next.top    = (out_row_reg == '0);
        item_next.bottom = (ROW_W'(out_row_reg) + ROW_W'(1) == dim_reg);
        item_next.left   = (out_col_reg == '0);
        item_next.right  = (ROW_W'(out_col_reg) + ROW_W'(1) == dim_reg);
        item_next.last   = item_next.bottom && item_next.right;
    end

    // the word at position dim*dim+dim closes the frame
    assign frame_end    = (in_row_reg == dim_reg + ROW_W'(1)) && (in_col_reg == '0);
    assign in_col_wrap  = (ROW_W'(in_col_reg) + ROW_W'(1) == dim_reg);
    assign out_col_wrap = item_next.right;

    always_comb
    begin
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        priority if (cfg_acc || (in_acc && frame_end))
        begin
            in_col_next  = '0;
            in_row_next  = '0;
            out_col_next = '0;
            out_row_next = '0;
        end
        else if (in_acc)
        begin
            if (in_col_wrap)
            begin
                in_col_next = '0;
                in_row_next = in_row_reg + ROW_W'(1);
            end
            else
            begin
                in_col_next = in_col_reg + COL_W'(1);
            end
            if (item_next.emit)
            begin
                if (out_col_wrap)
                begin
                    out_col_next = '0;
                    out_row_next = out_row_reg + COL_W'(1);
                end
                else
                begin
                    out_col_next = out_col_reg + COL_W'(1);
                end
            end
        end
        else
        begin
            // no word taken: positions hold
            in_col_next  = in_col_reg;
            in_row_next  = in_row_reg;
            out_col_next = out_col_reg;
            out_row_next = out_row_reg;
        end
    end

    // flush words enter the window as zero pixels
    always_comb
    begin
        for (int l = 0; l < NL; l++)
        begin
            pix_next[l*CHANNEL_BITS +: CHANNEL_BITS] = s_axis_tuser[0] ? '0 :
                s_axis_tdata[l*PB +: CHANNEL_BITS];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (in_acc) state_next = ST_SHIFT;
            ST_SHIFT: state_next = item_reg.emit ? ST_SUM : ST_IDLE;
            ST_SUM:   state_next = ST_OUT;
            ST_OUT:   if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            item_reg    <= '0;
            dim_reg     <= ROW_W'(RESET_DIM);
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
            if (cfg_acc)
            begin
                dim_reg <= dim_next;
            end
            if (in_acc)
            begin
                item_reg <= item_next;
            end
        end
    end

    // word payload
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            col_reg <= in_col_reg;
            pix_reg <= pix_next;
        end
    end

    // line store read on accept, written back in the next cycle (shift state)
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            older_q_reg <= older_mem[in_col_reg];
            newer_q_reg <= newer_mem[in_col_reg];
        end
        if (state_reg == ST_SHIFT)
        begin
            older_mem[col_reg] <= newer_q_reg;
            newer_mem[col_reg] <= pix_reg;
        end
    end

    // lane control
    always_comb
    begin
        lane_ctrl.shift  = (state_reg == ST_SHIFT);
        lane_ctrl.sum_en = (state_reg == ST_SUM);
        lane_ctrl.row_ok = {!item_reg.bottom, 1'b1, !item_reg.top};
        lane_ctrl.col_ok = {!item_reg.right, 1'b1, !item_reg.left};
        priority if (item_reg.top && item_reg.bottom)
        begin
            lane_ctrl.div = bbc_pkg::DIV1;
        end
        else if ((item_reg.top || item_reg.bottom) && (item_reg.left || item_reg.right))
        begin
            lane_ctrl.div = bbc_pkg::DIV4;
        end
        else if (item_reg.top || item_reg.bottom || item_reg.left || item_reg.right)
        begin
            lane_ctrl.div = bbc_pkg::DIV6;
        end
        else
        begin
            lane_ctrl.div = bbc_pkg::DIV9;
        end
    end

    // one lane per color channel
    for (genvar l = 0; l < NL; l++)
    begin : g_lane
        bbc_lane #(
            .CHANNEL_BITS (CHANNEL_BITS)
        ) u_lane (
            .clk   (clk),
            .ctrl  (lane_ctrl),
            .older (older_q_reg[l*CHANNEL_BITS +: CHANNEL_BITS]),
            .newer (newer_q_reg[l*CHANNEL_BITS +: CHANNEL_BITS]),
            .pix   (pix_reg[l*CHANNEL_BITS +: CHANNEL_BITS]),
            .quot  (quot_all[l*CHANNEL_BITS +: CHANNEL_BITS])
        );
    end

    assign out_load = (state_reg == ST_OUT) && out_free;

    bbc_merge #(
        .CHANNEL_BITS (CHANNEL_BITS)
    ) u_merge (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (out_load),
        .quot_all      (quot_all),
        .last          (item_reg.last),
        .free          (out_free),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // input row never passes the frame end position
    a_in_row_bound: assert property (@(posedge clk) disable iff (!rst_n)
        in_row_reg <= dim_reg + ROW_W'(1))
        else $error("input row past frame end");

    // output center row always lies inside the image
    a_out_row_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ROW_W'(out_row_reg) < dim_reg)
        else $error("output row outside image");

    // closing word restarts both positions
    a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && frame_end && !cfg_acc) |=>
            (in_row_reg == '0) && (in_col_reg == '0) && (out_row_reg == '0))
        else $error("frame did not restart");

    // the closing word is the one that carries the last pixel
    a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && frame_end) |-> (item_next.emit && item_next.last))
        else $error("frame end without last pixel");

    // sum and divide steps run only for words with an output
    a_sum_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SUM) |-> item_reg.emit)
        else $error("sum step for word without output");

endmodule

// ===== verif/box_blur_3x3_edge_clipped_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_blur_3x3_edge_clipped_unit_test: self-checking bench of the 3x3 box blur
// streams square rgb frames, partial frames and stray flush/pixel words into
// the blur, tracks line stores and window in a scoreboard of its own and
// compares every output word, field by field, with the predicted clipped mean
// ----------------------------------------------------------------------------
module box_blur_3x3_edge_clipped_unit_test;

    localparam int PIX_BITS     = bbc_pkg::PIX_BITS;
    localparam int NUM_LANES    = bbc_pkg::NUM_LANES;
    localparam int CFG_BITS     = bbc_pkg::CFG_BITS;
    localparam int DIM_RESET    = bbc_pkg::DIM_RESET;
    localparam int MAX_DIM      = bbc_pkg::MAX_DIM_DEF;
    localparam int WORD_BITS    = NUM_LANES * PIX_BITS;
    // generous margin for a word still in flight after a drain
    localparam int DRAIN_CYCLES = 16;
    localparam int LIMIT_CYCLES = 400000;
    localparam int RANDOM_WORDS = 680;
    localparam int STALL_CYCLES = 300;
    // short runs at the full frame size end well before its first output
    localparam int SHORT_RUN    = 40;

    // tuser codes of the input stream
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    typedef enum int unsigned {
        FRAME_CLEAN,   // dim*dim pixels, then dim+1 flushes
        FRAME_NOISY,   // full length, word kinds at random
        FRAME_CUT      // stops early, restarted by a size write
    } frame_kind_t;

    typedef enum int unsigned {
        IDLE_SEND_LIGHT,   // sender gaps rare, receiver stalls often
        IDLE_RECV_LIGHT,   // the other way round
        IDLE_NONE
    } idle_mode_t;

    // one expected output word
    typedef struct packed {
        logic [PIX_BITS-1:0] red;
        logic [PIX_BITS-1:0] green;
        logic [PIX_BITS-1:0] blue;
        logic                last_pixel;
    } blur_out_t;

    // ------------------------------------------------------------------------
    // scoreboard: own copy of line stores, window and frame position
    // ------------------------------------------------------------------------
    class box_mean_tracker;
        logic [WORD_BITS-1:0] older_row [MAX_DIM];
        logic [WORD_BITS-1:0] newer_row [MAX_DIM];
        logic [WORD_BITS-1:0] window [3][3];   // [row oldest..newest][col left..right]
        int unsigned          word_pos;
        logic [CFG_BITS-1:0]  dim_reg;
        blur_out_t            expected_means [$];
        int unsigned          mismatches;
        int unsigned          outputs_checked;

        function new();
            foreach (older_row[i])
            begin
                older_row[i] = '0;
                newer_row[i] = '0;
            end
            foreach (window[r, c])
                window[r][c] = '0;
            word_pos        = 0;
            dim_reg         = CFG_BITS'(DIM_RESET);
            mismatches      = 0;
            outputs_checked = 0;
        endfunction

        // a size write restarts the frame, line stores keep their contents
        function void set_dim(logic [CFG_BITS-1:0] value);
            dim_reg  = value;
            word_pos = 0;
        endfunction

        function int unsigned pending();
            return expected_means.size();
        endfunction

        // note one accepted input word and queue the mean it causes
        function void take_word(logic op, logic [WORD_BITS-1:0] data);
            int unsigned          dim;
            int unsigned          pos;
            int unsigned          col;
            int unsigned          centre;
            int unsigned          crow;
            int unsigned          ccol;
            int unsigned          cnt;
            int unsigned          sum [NUM_LANES];
            int                   r;
            int                   c;
            int                   ch;
            logic [WORD_BITS-1:0] pix;
            blur_out_t            res;

            dim = (dim_reg == 0) ? 1 : ((dim_reg > MAX_DIM) ? MAX_DIM : dim_reg);
            pos = word_pos;
            col = pos % dim;
            // a flush word always carries a zero pixel into the stores
            pix = (op == OP_FLUSH) ? '0 : data;

            for (r = 0; r < 3; r++)
            begin
                window[r][0] = window[r][1];
                window[r][1] = window[r][2];
            end
            window[0][2]   = older_row[col];
            window[1][2]   = newer_row[col];
            window[2][2]   = pix;
            older_row[col] = newer_row[col];
            newer_row[col] = pix;

            if (pos >= dim + 1)
            begin
                centre = pos - dim - 1;
                crow   = centre / dim;
                ccol   = centre % dim;
                cnt    = 0;
                for (ch = 0; ch < NUM_LANES; ch++)
                    sum[ch] = 0;
                for (r = 0; r < 3; r++)
                begin
                    if ((r == 0 && crow == 0) || (r == 2 && crow + 1 >= dim))
                        continue;
                    for (c = 0; c < 3; c++)
                    begin
                        if ((c == 0 && ccol == 0) || (c == 2 && ccol + 1 >= dim))
                            continue;
                        for (ch = 0; ch < NUM_LANES; ch++)
                            sum[ch] += window[r][c][ch*PIX_BITS +: PIX_BITS];
                        cnt++;
                    end
                end
                res.red        = PIX_BITS'(sum[0] / cnt);
                res.green      = PIX_BITS'(sum[1] / cnt);
                res.blue       = PIX_BITS'(sum[2] / cnt);
                res.last_pixel = (centre == dim * dim - 1);
                expected_means.push_back(res);
            end

            word_pos = (pos >= dim * dim + dim) ? 0 : pos + 1;
        endfunction

        function void compare_field(string name, logic [PIX_BITS-1:0] want,
                                    logic [PIX_BITS-1:0] got);
            if (got !== want)
            begin
                $error("%s mismatch: expected %0d, actual %0d", name, want, got);
                mismatches++;
            end
        endfunction

        // check one accepted output word against the oldest expected mean
        function void check_word(logic [WORD_BITS-1:0] data, logic last);
            blur_out_t want;

            if (expected_means.size() == 0)
            begin
                $error("output word with nothing expected: tdata %h tlast %b", data, last);
                mismatches++;
                return;
            end
            want = expected_means.pop_front();
            outputs_checked++;
            compare_field("red_out",    want.red,   data[0*PIX_BITS +: PIX_BITS]);
            compare_field("green_out",  want.green, data[1*PIX_BITS +: PIX_BITS]);
            compare_field("blue_out",   want.blue,  data[2*PIX_BITS +: PIX_BITS]);
            compare_field("last_pixel", PIX_BITS'(want.last_pixel), PIX_BITS'(last));
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // block under test
    // ------------------------------------------------------------------------
    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_BITS-1:0]  cfg_data;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [WORD_BITS-1:0] s_axis_tdata;   // red_in, green_in, blue_in
    logic [0:0]           s_axis_tuser;   // opcode
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [WORD_BITS-1:0] m_axis_tdata;   // red_out, green_out, blue_out
    logic                 m_axis_tlast;   // last_pixel

    box_blur_3x3_edge_clipped_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    box_mean_tracker tracker;

    // idle rates in percent, set by the stimulus per phase
    int unsigned send_gap_pct   = 0;
    int unsigned recv_stall_pct = 0;

    // long receiver hold-off, requested by the stimulus, counted by the receiver
    int unsigned stall_req_seq  = 0;
    int unsigned stall_seen_seq = 0;
    int unsigned stall_left     = 0;

    int unsigned words_sent   = 0;
    int unsigned dims_written = 0;
    int unsigned cur_dim      = DIM_RESET;   // effective size seen by the stimulus
    int unsigned cycle_count  = 0;

    always #5 clk = ~clk;

    // ------------------------------------------------------------------------
    // receiver: random stalls, plus the long hold-off when one is requested
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (stall_req_seq != stall_seen_seq)
        begin
            stall_seen_seq = stall_req_seq;
            stall_left     = STALL_CYCLES;
        end
        if (stall_left != 0)
        begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // monitor: outputs are checked before the input of the same edge is noted,
    // so a word can never be matched by its own input
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
                tracker.check_word(m_axis_tdata, m_axis_tlast);
            if (s_axis_tvalid && s_axis_tready)
                tracker.take_word(s_axis_tuser[0], s_axis_tdata);
            if (cfg_valid && cfg_ready)
                tracker.set_dim(cfg_data);
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // driving tasks
    // ------------------------------------------------------------------------

    // channel value with the extremes weighted up
    function automatic logic [PIX_BITS-1:0] pick_channel();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            default: return PIX_BITS'($urandom);
        endcase
    endfunction

    // new frame size: mostly small, now and then a zero or a larger one
    function automatic logic [CFG_BITS-1:0] pick_dim();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 5)
            return '0;
        else if (roll < 15)
            return CFG_BITS'($urandom_range(12, 9));
        else
            return CFG_BITS'($urandom_range(8, 1));
    endfunction

    function automatic void set_idle(idle_mode_t mode);
        case (mode)
            IDLE_SEND_LIGHT:
            begin
                send_gap_pct   = 12;
                recv_stall_pct = 62;
            end
            IDLE_RECV_LIGHT:
            begin
                send_gap_pct   = 62;
                recv_stall_pct = 12;
            end
            default:
            begin
                send_gap_pct   = 0;
                recv_stall_pct = 0;
            end
        endcase
    endfunction

    // offer one word, return at the edge it is taken; tvalid stays high so
    // back-to-back words go out without a bubble
    task automatic send_word(input logic op, input logic [PIX_BITS-1:0] red,
                             input logic [PIX_BITS-1:0] green,
                             input logic [PIX_BITS-1:0] blue);
        while ($urandom_range(99) < send_gap_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {blue, green, red};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        words_sent++;
    endtask

    // sender pause until every expected word has come out
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (tracker.pending() != 0)
            @(posedge clk);
    endtask

    // size write, only with the block idle; the extra cycles cover a word
    // still in flight that produces no output
    task automatic write_dim(input logic [CFG_BITS-1:0] value);
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        dims_written++;
        cur_dim = (value == 0) ? 1 : ((value > MAX_DIM) ? MAX_DIM : value);
    endtask

    // run of random pixel words, used at the full frame size
    task automatic send_pixels(input int unsigned count);
        int unsigned n;
        for (n = 0; n < count; n++)
            send_word(OP_PIXEL, pick_channel(), pick_channel(), pick_channel());
    endtask

    task automatic send_frame(input int unsigned dim, input frame_kind_t kind);
        int unsigned total;
        int unsigned length;
        int unsigned k;
        logic        op;

        total  = dim * dim + dim + 1;
        length = (kind == FRAME_CUT) ? $urandom_range(total - 1, 1) : total;
        for (k = 0; k < length; k++)
        begin
            if (kind == FRAME_NOISY)
                op = ($urandom_range(3) == 0) ? OP_FLUSH : OP_PIXEL;
            else
                op = (k < dim * dim) ? OP_PIXEL : OP_FLUSH;
            send_word(op, pick_channel(), pick_channel(), pick_channel());
        end
    endtask

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    initial
    begin
        int unsigned rand_base;
        int unsigned progress;
        int unsigned roll;
        int unsigned k;
        frame_kind_t kind;
        bit          first_frame;
        bit          held_early;
        bit          held_late;

        tracker = new();
        rst_n         <= 1'b0;
        cfg_valid     <= 1'b0;
        cfg_data      <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= OP_PIXEL;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_idle(IDLE_SEND_LIGHT);

        // size after reset is the full 1024: no output this early in the frame
        send_pixels(SHORT_RUN);

        // size write of 0 acts as 1: the lone pixel is its own mean
        write_dim('0);
        send_word(OP_PIXEL, '1, '1, '1);
        send_word(OP_FLUSH, '1, '0, '1);
        send_word(OP_FLUSH, '0, '1, '0);

        // 2x2 of full-scale pixels: every output is a corner, sum of four maxima
        write_dim(CFG_BITS'(2));
        for (k = 0; k < 4; k++)
            send_word(OP_PIXEL, '1, '1, '1);
        for (k = 0; k < 3; k++)
            send_word(OP_FLUSH, 16'hA5A5, 16'h5A5A, '1);

        // 3x3: flush in a pixel slot inserts zero, pixel in a flush slot only
        // fills a padding position below the image
        write_dim(CFG_BITS'(3));
        for (k = 0; k < 9; k++)
        begin
            if (k == 4)
                send_word(OP_FLUSH, '1, '1, '1);
            else
                send_word(OP_PIXEL, (k % 2 == 1) ? 16'hFFFF : 16'h0000,
                          PIX_BITS'(k * 7000), PIX_BITS'(16'hFFFF - k));
        end
        for (k = 0; k < 4; k++)
        begin
            if (k == 1)
                send_word(OP_PIXEL, '1, '1, '1);
            else
                send_word(OP_FLUSH, 16'hA5A5, 16'hA5A5, 16'hA5A5);
        end

        // size above the limit acts as 1024, all size bits set
        write_dim('1);
        send_pixels(SHORT_RUN);

        // random frames: mostly well formed, some with stray kinds, some cut
        write_dim(pick_dim());
        rand_base   = words_sent;
        first_frame = 1'b1;
        held_early  = 1'b0;
        held_late   = 1'b0;
        while (words_sent - rand_base < RANDOM_WORDS)
        begin
            progress = ((words_sent - rand_base) * 3) / RANDOM_WORDS;
            set_idle(idle_mode_t'((progress > 2) ? 2 : progress));

            // long receiver hold while the sender keeps offering words
            if ((progress == 0 && !held_early) || (progress >= 2 && !held_late))
            begin
                if (progress == 0)
                    held_early = 1'b1;
                else
                    held_late = 1'b1;
                stall_req_seq++;
            end

            roll = $urandom_range(99);
            kind = (roll < 70) ? FRAME_CLEAN : ((roll < 85) ? FRAME_NOISY : FRAME_CUT);
            send_frame(cur_dim, kind);

            if (kind == FRAME_CUT || $urandom_range(99) < 35)
                write_dim(pick_dim());
            else if (first_frame || $urandom_range(3) == 0)
                wait_drained();
            first_frame = 1'b0;
        end

        // drain, then a few quiet cycles to catch stray output words
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d input words over %0d size writes, including short full-size runs",
                 words_sent, dims_written);
        $display("checked %0d output words, %0d mismatches",
                 tracker.outputs_checked, tracker.mismatches);
        if (tracker.mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/bbc_pkg.sv
rtl/bbc_lane.sv
rtl/bbc_merge.sv
rtl/box_blur_3x3_edge_clipped_unit.sv
verif/box_blur_3x3_edge_clipped_unit_test.sv
